>>> hw/rtl/ppgs_pkg.sv
// Package for the projection profile gap segmenter.
// Holds the transaction payload types, register indexes, reset values and sizes.
// Used by every module in hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package ppgs_pkg;

  localparam int LANES = 8;
  localparam int MAX_LINES = 4096;
  localparam int IDX_CAP_INT = (MAX_LINES - 1 > 4095) ? 4095 : (MAX_LINES - 1);
  localparam logic [11:0] IDX_CAP = 12'(IDX_CAP_INT);
  localparam logic [12:0] CNT_MAX = 13'd8191;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [1:0] REG_INK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_GAP = 2'd1;
  localparam logic [1:0] REG_MIN_FINAL_SPAN = 2'd2;
  localparam logic [1:0] REG_MARGIN = 2'd3;

  localparam logic [7:0] RST_INK_THRESHOLD = 8'd125;
  localparam logic [12:0] RST_MIN_GAP = 13'd11;
  localparam logic [12:0] RST_MIN_FINAL_SPAN = 13'd3;
  localparam logic [3:0] RST_MARGIN = 4'd1;

  typedef struct packed {
    logic [7:0] pixel_0;
    logic [7:0] pixel_1;
    logic [7:0] pixel_2;
    logic [7:0] pixel_3;
    logic [7:0] pixel_4;
    logic [7:0] pixel_5;
    logic [7:0] pixel_6;
    logic [7:0] pixel_7;
    logic [3:0] pixels_valid;
    logic       end_of_line;
    logic       end_of_frame;
  } ppgs_in_t;

  typedef struct packed {
    logic [11:0] segment_start;
    logic [11:0] segment_end;
    logic        final_segment;
    logic        last;
  } ppgs_out_t;

  typedef struct packed {
    logic [1:0] count;
    ppgs_out_t  res0;
    ppgs_out_t  res1;
  } ppgs_push_t;

  typedef struct packed {
    logic [12:0] min_gap;
    logic [12:0] min_final_span;
    logic [3:0]  margin;
  } ppgs_seg_cfg_t;

endpackage

>>> hw/rtl/ppgs_lane.sv
// One pixel lane of the segmenter: classifies one grey value as ink.
// Depends on ppgs_pkg.
`timescale 1ns / 1ps

module ppgs_lane
  import ppgs_pkg::*;
(
  input  logic [7:0] pixel,
  input  logic [7:0] threshold,
  input  logic       enable,
  output logic       ink
);

  assign ink = enable && (pixel <= threshold);

endmodule

>>> hw/rtl/ppgs_merge.sv
// Merging stage: sums the lane ink flags into the line profile and runs the
// segment tracking state. Depends on ppgs_pkg.
`timescale 1ns / 1ps

module ppgs_merge
  import ppgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [LANES-1:0] lane_ink,
  input  logic             end_of_line,
  input  logic             end_of_frame,
  input  ppgs_seg_cfg_t    cfg,
  output ppgs_push_t       push
);

  logic [12:0] line_ink_count;
  logic [11:0] line_index;
  logic        segment_open;
  logic [11:0] segment_first_line;
  logic [11:0] last_ink_line;
  logic [12:0] blank_run;

  logic [3:0]  item_ink;
  logic [13:0] cnt_wide;
  logic [12:0] cnt_sum;
  logic [12:0] gap;
  logic        has_ink;
  logic        emit_mid;
  logic        emit_fin;
  logic        open_next;
  logic [11:0] first_next;
  logic [11:0] last_ink_next;
  logic [12:0] blank_next;
  logic [12:0] span;
  logic        line_done;
  ppgs_out_t   res_mid;
  ppgs_out_t   res_fin;

  function automatic ppgs_out_t make_res(input logic [11:0] first, input logic [11:0] lastl,
                                         input logic [11:0] cap, input logic [3:0] mrg,
                                         input logic fin);
    ppgs_out_t   r;
    logic [12:0] e;
    r.segment_start = (first >= {8'd0, mrg}) ? (first - {8'd0, mrg}) : 12'd0;
    e = {1'b0, lastl} + {9'd0, mrg};
    r.segment_end = (e > {1'b0, cap}) ? cap : e[11:0];
    r.final_segment = fin;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    item_ink = '0;
    for (int i = 0; i < LANES; i++) begin
      item_ink = item_ink + {3'd0, lane_ink[i]};
    end
  end

  assign cnt_wide = {1'b0, line_ink_count} + {10'd0, item_ink};
  assign cnt_sum = (cnt_wide > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_wide[12:0];
  assign gap = (cfg.min_gap == 13'd0) ? 13'd1 : cfg.min_gap;
  assign has_ink = (cnt_sum != 13'd0);
  assign line_done = item_valid && (end_of_line || end_of_frame);
  assign emit_mid = has_ink && segment_open && (blank_run >= gap);

  always_comb begin
    open_next = segment_open;
    first_next = segment_first_line;
    last_ink_next = last_ink_line;
    blank_next = blank_run;
    if (has_ink) begin
      open_next = 1'b1;
      if (!segment_open || emit_mid) begin
        first_next = line_index;
      end
      last_ink_next = line_index;
      blank_next = '0;
    end else if (segment_open && (blank_run < CNT_MAX)) begin
      blank_next = blank_run + 13'd1;
    end
  end

  assign span = {1'b0, last_ink_next - first_next} + 13'd1;
  assign emit_fin = end_of_frame && open_next && (span >= cfg.min_final_span);

  assign res_mid = make_res(segment_first_line, last_ink_line, line_index, cfg.margin, 1'b0);
  assign res_fin = make_res(first_next, last_ink_next, line_index, cfg.margin, 1'b1);

  always_comb begin
    push.count = '0;
    push.res0 = res_mid;
    push.res1 = res_fin;
    push.res1.last = 1'b1;
    if (line_done) begin
      if (emit_mid && emit_fin) begin
        push.count = 2'd2;
      end else if (emit_mid) begin
        push.count = 2'd1;
        push.res0.last = 1'b1;
      end else if (emit_fin) begin
        push.count = 2'd1;
        push.res0 = res_fin;
        push.res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_ink_count <= '0;
      line_index <= '0;
      segment_open <= 1'b0;
      segment_first_line <= '0;
      last_ink_line <= '0;
      blank_run <= '0;
    end else if (line_done) begin
      line_ink_count <= '0;
      if (end_of_frame) begin
        line_index <= '0;
        segment_open <= 1'b0;
        segment_first_line <= '0;
        last_ink_line <= '0;
        blank_run <= '0;
      end else begin
        segment_open <= open_next;
        segment_first_line <= first_next;
        last_ink_line <= last_ink_next;
        blank_run <= blank_next;
        if (line_index < IDX_CAP) begin
          line_index <= line_index + 12'd1;
        end
      end
    end else if (item_valid) begin
      line_ink_count <= cnt_sum;
    end
  end

endmodule

>>> hw/rtl/ppgs_queue.sv
// Result queue: takes up to two results per cycle from the merging stage and
// presents one per transaction on the output channel. Depends on ppgs_pkg.
`timescale 1ns / 1ps

module ppgs_queue
  import ppgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ppgs_push_t        push,
  output logic [QCNT_W-1:0] fill,
  output logic              out_valid,
  input  logic              out_stall,
  output ppgs_out_t         out_data
);

  ppgs_out_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign out_valid = (fill != '0);
  assign pop = out_valid && !out_stall;
  assign out_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule

>>> hw/rtl/projection_profile_gap_segmenter.sv
// Top level of the projection profile gap segmenter; holds the configuration
// registers, the pixel lanes and the lane register. Depends on ppgs_pkg,
// ppgs_lane, ppgs_merge and ppgs_queue.
//
// Each input transaction carries eight grey pixels, compared in eight parallel
// lanes, and the block takes one transaction per clock while in_stall is low.
// A transaction is captured in the lane register and then folded into the line
// profile and segment state; a result that this yields is registered in the
// queue before it appears on the output. Results wait in an eight-entry
// queue; the output port moves one result per transaction, so a frame end
// that closes two segments takes two output transactions, and input stalls
// only while the queue is close to full.
`timescale 1ns / 1ps

module projection_profile_gap_segmenter
  import ppgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  ppgs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ppgs_out_t   out_data
);

  logic [7:0]        ink_threshold;
  ppgs_seg_cfg_t     seg_cfg;
  logic [7:0]        pixels [LANES];
  logic [LANES-1:0]  lane_en;
  logic [LANES-1:0]  lane_ink;
  logic              a_valid;
  logic [LANES-1:0]  a_ink;
  logic              a_eol;
  logic              a_eof;
  logic              accept;
  ppgs_push_t        push;
  logic [QCNT_W-1:0] fill;
  logic [QCNT_W:0]   fill_need;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_threshold <= RST_INK_THRESHOLD;
      seg_cfg.min_gap <= RST_MIN_GAP;
      seg_cfg.min_final_span <= RST_MIN_FINAL_SPAN;
      seg_cfg.margin <= RST_MARGIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INK_THRESHOLD:  ink_threshold <= cfg_data[7:0];
        REG_MIN_GAP:        seg_cfg.min_gap <= cfg_data;
        REG_MIN_FINAL_SPAN: seg_cfg.min_final_span <= cfg_data;
        REG_MARGIN:         seg_cfg.margin <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign pixels[0] = in_data.pixel_0;
  assign pixels[1] = in_data.pixel_1;
  assign pixels[2] = in_data.pixel_2;
  assign pixels[3] = in_data.pixel_3;
  assign pixels[4] = in_data.pixel_4;
  assign pixels[5] = in_data.pixel_5;
  assign pixels[6] = in_data.pixel_6;
  assign pixels[7] = in_data.pixel_7;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign lane_en[g] = (4'(g) < in_data.pixels_valid);
    ppgs_lane u_lane (
      .pixel     (pixels[g]),
      .threshold (ink_threshold),
      .enable    (lane_en[g]),
      .ink       (lane_ink[g])
    );
  end

  assign fill_need = {1'b0, fill} + (a_valid ? (QCNT_W + 1)'(2) : '0);
  assign in_stall = (fill_need > (QCNT_W + 1)'(QUEUE_DEPTH - 2));
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_ink <= lane_ink;
    a_eol <= in_data.end_of_line;
    a_eof <= in_data.end_of_frame;
  end

  ppgs_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (a_valid),
    .lane_ink     (a_ink),
    .end_of_line  (a_eol),
    .end_of_frame (a_eof),
    .cfg          (seg_cfg),
    .push         (push)
  );

  ppgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .fill      (fill),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/tb_projection_profile_gap_segmenter.sv
// Testbench for projection_profile_gap_segmenter: directed and random pixel streams,
// with segments predicted by a behavioral model of the line profile and checked in order.
// Depends on ppgs_pkg and the RTL top level under hw/rtl.
`timescale 1ns / 1ps

module tb_projection_profile_gap_segmenter;
  import ppgs_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 270;
  localparam int RANDOM_PHASES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_INK_THRESHOLD;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ppgs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ppgs_out_t out_data;

  logic [7:0] thr_cfg = RST_INK_THRESHOLD;
  logic [12:0] gap_cfg = RST_MIN_GAP;
  logic [12:0] span_cfg = RST_MIN_FINAL_SPAN;
  logic [3:0] margin_cfg = RST_MARGIN;

  logic [12:0] ink_in_line = '0;
  logic [11:0] line_no = '0;
  logic seg_open = 1'b0;
  logic [11:0] seg_first = '0;
  logic [11:0] seg_last_ink = '0;
  logic [12:0] blank_lines = '0;

  ppgs_out_t seg_expect[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b0;
  int hold_left = 0;

  projection_profile_gap_segmenter dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic ppgs_out_t make_segment(input logic [11:0] first, input logic [11:0] lastl,
                                             input logic [11:0] cap, input logic fin);
    ppgs_out_t seg;
    int unsigned stop;
    stop = lastl + margin_cfg;
    if (stop > cap) stop = cap;
    seg.segment_start = (first >= margin_cfg) ? first - margin_cfg : 12'd0;
    seg.segment_end = 12'(stop);
    seg.final_segment = fin;
    seg.last = 1'b0;
    return seg;
  endfunction

  function automatic void predict_segments(input ppgs_in_t word);
    logic [8*LANES-1:0] grey;
    int unsigned n_real;
    int unsigned gap_need;
    int unsigned span;
    ppgs_out_t made[2];
    int made_n;
    grey = {word.pixel_0, word.pixel_1, word.pixel_2, word.pixel_3,
            word.pixel_4, word.pixel_5, word.pixel_6, word.pixel_7};
    n_real = (word.pixels_valid > LANES) ? LANES : word.pixels_valid;
    gap_need = (gap_cfg == 0) ? 1 : gap_cfg;
    made_n = 0;
    for (int i = 0; i < n_real; i++) begin
      if (grey[8*(LANES-1-i) +: 8] <= thr_cfg && ink_in_line != CNT_MAX) ink_in_line++;
    end
    if (!(word.end_of_line || word.end_of_frame)) return;
    if (ink_in_line != 0) begin
      if (!seg_open) begin
        seg_open = 1'b1;
        seg_first = line_no;
      end else if (blank_lines >= gap_need) begin
        made[made_n] = make_segment(seg_first, seg_last_ink, line_no, 1'b0);
        made_n++;
        seg_first = line_no;
      end
      seg_last_ink = line_no;
      blank_lines = '0;
    end else if (seg_open && blank_lines != CNT_MAX) begin
      blank_lines++;
    end
    ink_in_line = '0;
    if (word.end_of_frame) begin
      span = seg_last_ink - seg_first + 1;
      if (seg_open && span >= span_cfg) begin
        made[made_n] = make_segment(seg_first, seg_last_ink, line_no, 1'b1);
        made_n++;
      end
      line_no = '0;
      seg_open = 1'b0;
      seg_first = '0;
      seg_last_ink = '0;
      blank_lines = '0;
    end else if (line_no != IDX_CAP) begin
      line_no++;
    end
    for (int k = 0; k < made_n; k++) begin
      if (k == made_n - 1) made[k].last = 1'b1;
      seg_expect.insert(seg_expect.size(), made[k]);
    end
  endfunction

  function automatic void check_segment(input ppgs_out_t want, input ppgs_out_t got);
    if (got.segment_start !== want.segment_start) begin
      $error("segment_start expected %0d got %0d", want.segment_start, got.segment_start);
      errors++;
    end
    if (got.segment_end !== want.segment_end) begin
      $error("segment_end expected %0d got %0d", want.segment_end, got.segment_end);
      errors++;
    end
    if (got.final_segment !== want.final_segment) begin
      $error("final_segment expected %0d got %0d", want.final_segment, got.final_segment);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d got %0d", want.last, got.last);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (seg_expect.size() == 0) begin
        $error("unexpected segment %0d..%0d", out_data.segment_start, out_data.segment_end);
        errors++;
      end else begin
        check_segment(seg_expect.pop_front(), out_data);
      end
    end
    if (idle_on && hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      hold_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic ppgs_in_t flat_word(input logic [7:0] grey, input logic [3:0] nv,
                                         input logic eol, input logic eof);
    return ppgs_in_t'({{LANES{grey}}, nv, eol, eof});
  endfunction

  function automatic ppgs_in_t rand_word(input bit inky, input logic eol, input logic eof);
    logic [8*LANES-1:0] grey;
    logic [3:0] nv;
    for (int i = 0; i < LANES; i++) begin
      if ((inky && $urandom_range(0, 2) == 0) || thr_cfg == 8'hFF) begin
        grey[8*i +: 8] = 8'($urandom_range(0, thr_cfg));
      end else begin
        grey[8*i +: 8] = 8'($urandom_range(thr_cfg + 1, 255));
      end
    end
    nv = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'(LANES);
    return ppgs_in_t'({grey, nv, eol, eof});
  endfunction

  task automatic send_pixels(input ppgs_in_t word);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (in_stall);
    predict_segments(word);
  endtask

  task automatic wait_for_segments();
    in_valid <= 1'b0;
    while (seg_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] thr, input logic [12:0] gap,
                               input logic [12:0] span, input logic [3:0] mrg);
    put_reg(REG_INK_THRESHOLD, 13'(thr));
    put_reg(REG_MIN_GAP, gap);
    put_reg(REG_MIN_FINAL_SPAN, span);
    put_reg(REG_MARGIN, 13'(mrg));
    cfg_write <= 1'b0;
    thr_cfg = thr;
    gap_cfg = gap;
    span_cfg = span;
    margin_cfg = mrg;
  endtask

  task automatic test_reset_values();
    send_pixels(ppgs_in_t'({{(LANES-1){8'd255}}, 8'd0, 4'd7, 1'b1, 1'b0}));
    send_pixels(flat_word(8'd0, 4'd0, 1'b1, 1'b0));
    send_pixels(flat_word(8'd255, 4'd8, 1'b0, 1'b0));
    send_pixels(flat_word(8'd125, 4'd1, 1'b1, 1'b0));
    send_pixels(ppgs_in_t'({{(LANES-1){8'd255}}, 8'd0, 4'd8, 1'b1, 1'b0}));
    send_pixels(flat_word(8'd0, 4'd15, 1'b1, 1'b0));
    send_pixels(flat_word(8'd124, 4'd9, 1'b0, 1'b1));
    send_pixels(flat_word(8'd0, 4'd8, 1'b1, 1'b1));
    send_pixels(flat_word(8'd255, 4'd8, 1'b0, 1'b1));
  endtask

  task automatic test_two_results();
    wait_for_segments();
    load_settings(8'd0, 13'd1, 13'd0, 4'd15);
    send_pixels(flat_word(8'd0, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd1, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd0, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd1, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd0, 4'd8, 1'b1, 1'b1));
  endtask

  task automatic test_gap_zero();
    wait_for_segments();
    load_settings(8'd255, 13'd0, 13'd4096, 4'd0);
    send_pixels(flat_word(8'd255, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd255, 4'd0, 1'b1, 1'b0));
    send_pixels(flat_word(8'd255, 4'd8, 1'b1, 1'b1));
  endtask

  task automatic test_long_line();
    wait_for_segments();
    load_settings(8'd255, 13'd1, 13'd1, 4'd2);
    repeat (8192 / LANES - 1) send_pixels(flat_word(8'd7, 4'd8, 1'b0, 1'b0));
    send_pixels(flat_word(8'd7, 4'd8, 1'b1, 1'b0));
    send_pixels(flat_word(8'd7, 4'd0, 1'b1, 1'b0));
    send_pixels(flat_word(8'd7, 4'd8, 1'b1, 1'b1));
  endtask

  task automatic run_random_phase(input int items);
    int sent;
    int lines;
    int words;
    int run_left;
    int gap_need;
    bit inky;
    logic eof;
    sent = 0;
    gap_need = (gap_cfg == 0) ? 1 : gap_cfg;
    while (sent < items) begin
      if ($urandom_range(0, 11) == 0) begin
        send_pixels(rand_word($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                              $urandom_range(0, 4) == 0));
        sent++;
      end else begin
        lines = $urandom_range(1, 3 * gap_need + 12);
        inky = ($urandom_range(0, 1) == 1);
        run_left = $urandom_range(0, 3);
        for (int l = 0; l < lines; l++) begin
          if (run_left == 0) begin
            inky = !inky;
            run_left = inky ? $urandom_range(1, 4) : $urandom_range(1, gap_need + 2);
          end
          run_left--;
          words = $urandom_range(1, 3);
          for (int w = 0; w < words; w++) begin
            eof = (l == lines - 1) && (w == words - 1);
            send_pixels(rand_word(inky,
                                  (w == words - 1) && (!eof || $urandom_range(0, 1) == 1),
                                  eof));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_segments();
      load_settings(8'($urandom_range(0, 254)),
                    13'((p == 3) ? $urandom_range(8, 20) : $urandom_range(0, 5)),
                    13'($urandom_range(0, 6)), 4'($urandom_range(0, 15)));
      idle_on = (p % 2 == 0) && (p != RANDOM_PHASES - 1);
      run_random_phase(RANDOM_ITEMS / RANDOM_PHASES);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_reset_values();
    test_two_results();
    test_gap_zero();
    test_long_line();
    test_random();
    wait_for_segments();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
